// File: rtl/shortest_path_adjacency_matrix_top_defines.svh
// ----------------------------------------------------------------------------
// Shortest path block: assertion macros
// Shared concurrent assertion forms for the checker of the path search block.
// ----------------------------------------------------------------------------
`ifndef SHORTEST_PATH_ADJACENCY_MATRIX_TOP_DEFINES_SVH
`define SHORTEST_PATH_ADJACENCY_MATRIX_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPADJ_ASSERT_SAME(label, ck, rst_n, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("spadj checker: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SPADJ_ASSERT_NEXT(label, ck, rst_n, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("spadj checker: assertion failed");

`endif

// File: rtl/spadj_pkg.sv
// ----------------------------------------------------------------------------
// Shortest path block: shared package
// Sizes, field widths, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package spadj_pkg;

	localparam int MAX_VERTICES = 16;
	localparam int WEIGHT_BITS  = 16;

	localparam int VW         = $clog2(MAX_VERTICES);
	localparam int CW         = $clog2(MAX_VERTICES + 1);
	localparam int EDGE_AW    = 2 * VW;
	localparam int EDGE_DEPTH = 2 ** EDGE_AW;

	// Fixed widths of the channel fields.
	localparam int FIELD_VW  = 4;
	localparam int WEIGHT_FW = 16;
	localparam int COST_W    = 20;
	localparam int CFG_W     = 5;

	localparam int SUM_W = ((WEIGHT_BITS > COST_W) ? WEIGHT_BITS : COST_W) + 1;

	localparam logic [COST_W-1:0] COST_MAX         = '1;
	localparam logic [CFG_W-1:0]  VERTEX_COUNT_RST = CFG_W'(16);

	typedef enum logic {
		OP_WRITE,
		OP_FIND
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_RELAX,
		ST_DRAIN,
		ST_SELECT,
		ST_WALK,
		ST_EMIT,
		ST_UNREACH
	} state_t;

endpackage

// File: rtl/spadj_ifs.sv
// ----------------------------------------------------------------------------
// Shortest path block: channel interfaces
// Request, response and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface spadj_req_if import spadj_pkg::*; ();
	logic                 valid;
	logic                 ready;
	op_t                  operation;
	logic [FIELD_VW-1:0]  row;
	logic [FIELD_VW-1:0]  col;
	logic [WEIGHT_FW-1:0] weight;
	logic [FIELD_VW-1:0]  source_vertex;
	logic [FIELD_VW-1:0]  sink_vertex;

	modport source (output valid, operation, row, col, weight, source_vertex, sink_vertex,
		input ready);
	modport sink (input valid, operation, row, col, weight, source_vertex, sink_vertex,
		output ready);
endinterface

interface spadj_rsp_if import spadj_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [FIELD_VW-1:0] vertex;
	logic [COST_W-1:0]   path_cost;
	logic                unreachable;
	logic                last;

	modport source (output valid, vertex, path_cost, unreachable, last, input ready);
	modport sink (input valid, vertex, path_cost, unreachable, last, output ready);
endinterface

interface spadj_cfg_if import spadj_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] vertex_count;

	modport source (output valid, vertex_count, input ready);
	modport sink (input valid, vertex_count, output ready);
endinterface

// File: rtl/spadj_ram.sv
// ----------------------------------------------------------------------------
// Shortest path block: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spadj_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/shortest_path_adjacency_matrix_top.sv
// ----------------------------------------------------------------------------
// Shortest path search over a directed weighted adjacency matrix
// Edge weight store with Dijkstra search and a path emitter, driven by a
// small sequencer around one shared add/compare unit.
// ----------------------------------------------------------------------------
// The req channel carries two kinds of transaction. A write stores one edge
// weight (zero meaning no edge) and leaves the block ready, so a loader may
// stream writes back to back. A find names a source and a sink; the block then
// drops ready until the search has finished and its last result is registered.
// The rsp channel returns the path, one vertex per transaction with the source
// first, each carrying the total cost; the final one has last set. An
// unreachable sink, or an out-of-range source or sink, gives a single
// transaction flagged unreachable. The cfg channel sets the active vertex
// count n; it is always ready and must only be written while the block is idle.
// A find repeats a check of the sink, a relax pass over the current vertex's
// row, a drain and a select pass for the nearest unsettled vertex until the
// sink is settled, then walks predecessors back and emits the path. The edge
// store's single read port and the one-vertex-per-cycle compare unit set its pace.
// Reset clears the edge valid bits at once, so the whole matrix reads as empty,
// and the vertex count returns to 16. A stalled rsp holds its output register;
// writes are accepted meanwhile only while idle, but no further result can leave.
// ----------------------------------------------------------------------------
module shortest_path_adjacency_matrix_top import spadj_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	spadj_req_if.sink      req,
	spadj_rsp_if.source    rsp,
	spadj_cfg_if.sink      cfg
);

	// Sequencer and configuration.
	state_t           state_q, state_d;
	logic [CFG_W-1:0] vcount_q;
	logic [CW-1:0]    n_act;

	// Edge store and its valid bits; a cleared valid bit reads as no edge.
	logic [EDGE_DEPTH-1:0]  edge_vld_q;
	logic                   ram_we;
	logic [EDGE_AW-1:0]     ram_waddr;
	logic [WEIGHT_BITS-1:0] ram_wdata;
	logic [EDGE_AW-1:0]     ram_raddr;
	logic [WEIGHT_BITS-1:0] ram_rdata;
	logic                   rd_go_s1;
	logic                   rd_vld_s1;
	logic [VW-1:0]          rd_idx_s1;

	// Search scratch state.
	logic [MAX_VERTICES-1:0] reached_q;
	logic [MAX_VERTICES-1:0] visited_q;
	logic [COST_W-1:0]       dist_q  [MAX_VERTICES];
	logic [VW-1:0]           pred_q  [MAX_VERTICES];
	logic [VW-1:0]           stack_q [MAX_VERTICES];

	logic [VW-1:0]     src_q, snk_q, cur_q, best_q, v_q;
	logic [COST_W-1:0] cur_dist_q, best_dist_q, path_cost_q;
	logic              found_q;
	logic [CW-1:0]     steps_q, idx_q, len_q, emit_q;

	// Output register.
	logic                rsp_vld_q;
	logic [FIELD_VW-1:0] out_vertex_q;
	logic [COST_W-1:0]   out_cost_q;
	logic                out_unr_q;
	logic                out_last_q;

	// Combinational helpers.
	logic                    req_fire;
	logic                    find_fire;
	logic                    find_bad;
	logic [VW-1:0]           req_src_v;
	logic [MAX_VERTICES-1:0] src_1h;
	logic                    out_free;
	logic                    out_load;
	logic [FIELD_VW-1:0]     out_vertex_d;
	logic [COST_W-1:0]       out_cost_d;
	logic                    out_unr_d;
	logic                    out_last_d;
	logic [VW-1:0]           sc_addr;
	logic [COST_W-1:0]       dist_rd;
	logic                    reached_rd;
	logic                    visited_rd;
	logic [WEIGHT_BITS-1:0]  w_s1;
	logic [SUM_W-1:0]        sum;
	logic [COST_W-1:0]       nd;
	logic                    relax_upd;
	logic                    take;
	logic                    found_n;
	logic [VW-1:0]           best_n;
	logic [COST_W-1:0]       best_dist_n;
	logic                    last_idx;
	logic                    walk_more;
	logic [VW-1:0]           pred_v;
	logic                    emit_last;
	logic [CW-1:0]           sidx;

	// A count of zero acts as one; anything above the bound acts as the bound.
	always_comb begin
		if (vcount_q == '0) begin
			n_act = CW'(1);
		end else if (32'(vcount_q) > MAX_VERTICES) begin
			n_act = CW'(MAX_VERTICES);
		end else begin
			n_act = CW'(vcount_q);
		end
	end

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign req_fire  = req.valid && req.ready;
	assign find_fire = req_fire && (req.operation == OP_FIND);
	assign find_bad  = (32'(req.source_vertex) >= 32'(n_act)) ||
	                   (32'(req.sink_vertex) >= 32'(n_act));
	assign req_src_v = VW'(req.source_vertex);

	always_comb begin
		src_1h            = '0;
		src_1h[req_src_v] = 1'b1;
	end

	// Edge writes outside the matrix are dropped.
	assign ram_we    = req_fire && (req.operation == OP_WRITE) &&
	                   (32'(req.row) < MAX_VERTICES) && (32'(req.col) < MAX_VERTICES);
	assign ram_waddr = {VW'(req.row), VW'(req.col)};
	assign ram_wdata = WEIGHT_BITS'(req.weight);
	assign ram_raddr = {cur_q, idx_q[VW-1:0]};

	spadj_ram #(
		.WIDTH (WEIGHT_BITS),
		.DEPTH (EDGE_DEPTH)
	) u_edge_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// One read address serves the scratch arrays in every state.
	always_comb begin
		unique case (state_q)
			ST_SELECT: sc_addr = idx_q[VW-1:0];
			ST_CHECK:  sc_addr = snk_q;
			default:   sc_addr = rd_idx_s1;
		endcase
	end

	assign dist_rd    = dist_q[sc_addr];
	assign reached_rd = reached_q[sc_addr];
	assign visited_rd = visited_q[sc_addr];

	// Relaxation: the shared adder with saturation at the largest cost.
	assign w_s1      = rd_vld_s1 ? ram_rdata : '0;
	assign sum       = SUM_W'(cur_dist_q) + SUM_W'(w_s1);
	assign nd        = (sum > SUM_W'(COST_MAX)) ? COST_MAX : COST_W'(sum);
	assign relax_upd = rd_go_s1 && (w_s1 != '0) && (!reached_rd || (nd < dist_rd));

	// Selection: a strict compare keeps the lowest-numbered vertex on a tie.
	assign take        = reached_rd && !visited_rd && (!found_q || (dist_rd < best_dist_q));
	assign found_n     = found_q || take;
	assign best_n      = take ? idx_q[VW-1:0] : best_q;
	assign best_dist_n = take ? dist_rd : best_dist_q;
	assign last_idx    = (idx_q == CW'(n_act - 1'b1));

	assign walk_more = (v_q != src_q) && (len_q < n_act);
	assign pred_v    = pred_q[v_q];

	assign out_free  = !rsp_vld_q || rsp.ready;
	assign emit_last = (CW'(emit_q + 1'b1) == len_q);
	assign sidx      = CW'(len_q - emit_q - 1'b1);

	always_comb begin
		state_d      = state_q;
		out_load     = 1'b0;
		out_vertex_d = '0;
		out_cost_d   = '0;
		out_unr_d    = 1'b0;
		out_last_d   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (find_fire) begin
					state_d = find_bad ? ST_UNREACH : ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (visited_rd) begin
					state_d = ST_WALK;
				end else if (steps_q >= n_act) begin
					state_d = ST_UNREACH;
				end else begin
					state_d = ST_RELAX;
				end
			end
			ST_RELAX: begin
				if (last_idx) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_SELECT;
			end
			ST_SELECT: begin
				if (last_idx) begin
					state_d = found_n ? ST_CHECK : ST_UNREACH;
				end
			end
			ST_WALK: begin
				if (!walk_more) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					out_load     = 1'b1;
					out_vertex_d = FIELD_VW'(stack_q[sidx[VW-1:0]]);
					out_cost_d   = path_cost_q;
					out_last_d   = emit_last;
					if (emit_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_UNREACH: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_unr_d  = 1'b1;
					out_last_d = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			vcount_q   <= VERTEX_COUNT_RST;
			edge_vld_q <= '0;
			rd_go_s1   <= 1'b0;
			rd_vld_s1  <= 1'b0;
			rsp_vld_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_go_s1  <= (state_q == ST_RELAX);
			rd_vld_s1 <= edge_vld_q[ram_raddr];
			if (cfg.valid && cfg.ready) begin
				vcount_q <= cfg.vertex_count;
			end
			if (ram_we) begin
				edge_vld_q[ram_waddr] <= 1'b1;
			end
			if (out_load) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q[VW-1:0];

		if (relax_upd) begin
			reached_q[rd_idx_s1] <= 1'b1;
			dist_q[rd_idx_s1]    <= nd;
			pred_q[rd_idx_s1]    <= cur_q;
		end

		unique case (state_q)
			ST_IDLE: begin
				if (find_fire) begin
					src_q             <= req_src_v;
					snk_q             <= VW'(req.sink_vertex);
					cur_q             <= req_src_v;
					cur_dist_q        <= '0;
					steps_q           <= '0;
					reached_q         <= src_1h;
					visited_q         <= src_1h;
					dist_q[req_src_v] <= '0;
					pred_q[req_src_v] <= req_src_v;
				end
			end
			ST_CHECK: begin
				if (visited_rd) begin
					path_cost_q <= dist_rd;
					stack_q[0]  <= snk_q;
					v_q         <= snk_q;
					len_q       <= CW'(1);
				end else begin
					steps_q <= CW'(steps_q + 1'b1);
					idx_q   <= '0;
				end
			end
			ST_RELAX: begin
				idx_q <= CW'(idx_q + 1'b1);
			end
			ST_DRAIN: begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end
			ST_SELECT: begin
				found_q     <= found_n;
				best_q      <= best_n;
				best_dist_q <= best_dist_n;
				idx_q       <= CW'(idx_q + 1'b1);
				if (last_idx && found_n) begin
					cur_q             <= best_n;
					cur_dist_q        <= best_dist_n;
					visited_q[best_n] <= 1'b1;
				end
			end
			ST_WALK: begin
				if (walk_more) begin
					v_q                      <= pred_v;
					stack_q[len_q[VW-1:0]] <= pred_v;
					len_q                    <= CW'(len_q + 1'b1);
				end else begin
					emit_q <= '0;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					emit_q <= CW'(emit_q + 1'b1);
				end
			end
			default: begin
			end
		endcase

		if (out_load) begin
			out_vertex_q <= out_vertex_d;
			out_cost_q   <= out_cost_d;
			out_unr_q    <= out_unr_d;
			out_last_q   <= out_last_d;
		end
	end

	assign rsp.valid       = rsp_vld_q;
	assign rsp.vertex      = out_vertex_q;
	assign rsp.path_cost   = out_cost_q;
	assign rsp.unreachable = out_unr_q;
	assign rsp.last        = out_last_q;

endmodule

// File: rtl/spadj_checker.sv
// ----------------------------------------------------------------------------
// Shortest path block: port checker
// Watches the req and rsp channel ports of the top level over time.
// ----------------------------------------------------------------------------
`include "shortest_path_adjacency_matrix_top_defines.svh"

module spadj_checker import spadj_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input op_t                 req_operation,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [FIELD_VW-1:0] rsp_vertex,
	input logic [COST_W-1:0]   rsp_path_cost,
	input logic                rsp_unreachable,
	input logic                rsp_last
);

	// A stalled result stays offered and unchanged.
	`SPADJ_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)
	`SPADJ_ASSERT_NEXT(a_rsp_stable, clk, arst_n, rsp_valid && !rsp_ready, $stable(rsp_vertex) && $stable(rsp_path_cost) && $stable(rsp_unreachable) && $stable(rsp_last))

	// An unreachable result is always a lone, zeroed transaction.
	`SPADJ_ASSERT_SAME(a_unreach_form, clk, arst_n, rsp_valid && rsp_unreachable, rsp_last && (rsp_vertex == '0) && (rsp_path_cost == '0))

	// A find occupies the block; a write leaves it ready for the next one.
	`SPADJ_ASSERT_NEXT(a_find_busy, clk, arst_n, req_valid && req_ready && (req_operation == OP_FIND), !req_ready)
	`SPADJ_ASSERT_NEXT(a_write_ready, clk, arst_n, req_valid && req_ready && (req_operation == OP_WRITE), req_ready)

endmodule

bind shortest_path_adjacency_matrix_top spadj_checker u_spadj_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.req_operation   (req.operation),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_vertex      (rsp.vertex),
	.rsp_path_cost   (rsp.path_cost),
	.rsp_unreachable (rsp.unreachable),
	.rsp_last        (rsp.last)
);
